### sv/ssce_pkg.sv
// Shared constants for the sparse softmax cross-entropy block.
package ssce_pkg;

  // Sizing
  localparam int MAX_CLASSES = 1024;
  localparam int MAX_IGNORES = 4;
  localparam int NUM_IGN_REGS = 4;
  localparam int CLS_W = $clog2(MAX_CLASSES + 1);
  localparam int CMP_W = (CLS_W > 16) ? CLS_W : 16;

  // Field widths
  localparam int PROB_W = 17;
  localparam int LABEL_W = 16;
  localparam int VALUE_W = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IGN_CNT_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGN_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IGN_A     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGN_B     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IGN_C     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IGN_D     = 3'd5;

  // Logarithm unit
  localparam int FRAC_BITS = 24;
  localparam int STEP_W = $clog2(FRAC_BITS);
  localparam int EXP_W = 5;
  localparam int NEG_W = 29;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;

endpackage

### sv/sparse_softmax_cross_entropy.sv
// Sparse softmax cross-entropy: per-class gradient or per-position loss, iterative log unit.
//
// Input channel (in_valid / in_stall): one class probability per item, classes in
// order, each item tagged with the position's label and a last-class flag.
// Result channel (out_valid / out_stall): value, counted, label_error, end_of_position.
// Configuration (cfg_we / cfg_index / cfg_wdata): mode, ignore count, ignore labels a..d;
// to be written only while the block is idle; the block itself does not enforce this.
//
// Gradient mode: every item yields a result in the cycle after it is accepted; a new item
// is taken each cycle while the result register drains.
// Loss mode: only the last item of a position yields a result. Ignored positions and
// label errors answer in the cycle after acceptance. Otherwise -ln(p) runs on a single
// shared 32x32 multiplier under a small sequencer: normalize (one bit shift per cycle),
// repeated squaring for the 24 fraction bits of log2, one subtract, one scaling multiply
// and rounding. The input channel stalls until the result is handed over; other items of
// the position yield no result and do not start the sequencer.
// Reset is synchronous (rst_n low): configuration returns to its reset values, the
// position state clears and the result register empties.
// While the receiver stalls, the result holds and new items stall once a result waits.
module sparse_softmax_cross_entropy
  import ssce_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic        [PROB_W-1:0]    in_probability,
  input  logic signed [LABEL_W-1:0]   in_target_label,
  input  logic                        in_last_class,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VALUE_W-1:0]   out_value,
  output logic                        out_counted,
  output logic                        out_label_error,
  output logic                        out_end_of_position,
  input  logic                        cfg_we,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_wdata
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NORM = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_NEG  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_RND  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic                   mode_r, mode_nxt;
  logic [IGN_CNT_W-1:0]   ign_count_r, ign_count_nxt;
  logic [LABEL_W-1:0]     ign_label_r [NUM_IGN_REGS];
  logic [LABEL_W-1:0]     ign_label_nxt [NUM_IGN_REGS];
  logic [CLS_W-1:0]       class_index_r, class_index_nxt;
  logic [PROB_W-1:0]      capt_prob_r, capt_prob_nxt;
  logic                   seen_r, seen_nxt;

  logic [31:0]            x_r, x_nxt;
  logic [EXP_W-1:0]       exp_r, exp_nxt;
  logic [FRAC_BITS-1:0]   frac_r, frac_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [NEG_W-1:0]       neg_r, neg_nxt;
  logic [63:0]            prod_r, prod_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]     out_value_r, out_value_nxt;
  logic                   out_counted_r, out_counted_nxt;
  logic                   out_lerr_r, out_lerr_nxt;
  logic                   out_eop_r, out_eop_nxt;

  // Shared multiplier
  logic [31:0]            mul_a, mul_b;
  logic [63:0]            mul_p;

  logic                   accept;
  logic                   out_free;
  logic [PROB_W-1:0]      prob_c;
  logic [LABEL_W-1:0]     lbl_u;
  logic [IGN_CNT_W-1:0]   ign_eff;
  logic                   ignored;
  logic                   match;
  logic                   seen_now;
  logic [PROB_W-1:0]      capt_now;
  logic [PROB_W-1:0]      prob_floor;
  logic [32:0]            sq_t;
  logic [63:0]            rnd_sum;
  logic [19:0]            rnd_q;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign out_valid           = out_valid_r;
  assign out_value           = $signed(out_value_r);
  assign out_counted         = out_counted_r;
  assign out_label_error     = out_lerr_r;
  assign out_end_of_position = out_eop_r;

  // Pick multiplier operands: squaring or final ln2 scaling
  always_comb begin
    if (state_r == ST_MUL) begin
      mul_a = {{(32-NEG_W){1'b0}}, neg_r};
      mul_b = LN2_Q32;
    end else begin
      mul_a = x_r;
      mul_b = x_r;
    end
  end
  assign mul_p = mul_a * mul_b;
  assign sq_t  = mul_p[63:31];

  assign rnd_sum = prod_r + (64'd1 << 43);
  assign rnd_q   = rnd_sum[63:44];

  // Classify the incoming item
  always_comb begin
    prob_c = (in_probability > ONE_Q16) ? ONE_Q16 : in_probability;
    lbl_u  = $unsigned(in_target_label);
    ign_eff = (ign_count_r > IGN_CNT_W'(MAX_IGNORES)) ? IGN_CNT_W'(MAX_IGNORES) : ign_count_r;
    ignored = 1'b0;
    for (int k = 0; k < MAX_IGNORES; k++) begin
      if ((IGN_CNT_W'(k) < ign_eff) && (ign_label_r[k] == lbl_u)) begin
        ignored = 1'b1;
      end
    end
    match = !lbl_u[LABEL_W-1] && (class_index_r < CLS_W'(MAX_CLASSES))
            && (CMP_W'(lbl_u) == CMP_W'(class_index_r));
    seen_now   = seen_r || match;
    capt_now   = match ? prob_c : capt_prob_r;
    prob_floor = (capt_now == '0) ? PROB_W'(1) : capt_now;
  end

  // Next-state logic
  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    ign_count_nxt   = ign_count_r;
    ign_label_nxt   = ign_label_r;
    class_index_nxt = class_index_r;
    capt_prob_nxt   = capt_prob_r;
    seen_nxt        = seen_r;
    x_nxt           = x_r;
    exp_nxt         = exp_r;
    frac_nxt        = frac_r;
    step_nxt        = step_r;
    neg_nxt         = neg_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = out_valid_r;
    out_value_nxt   = out_value_r;
    out_counted_nxt = out_counted_r;
    out_lerr_nxt    = out_lerr_r;
    out_eop_nxt     = out_eop_r;

    // Drop a result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:      mode_nxt = cfg_wdata[0];
        REG_IGN_COUNT: ign_count_nxt = cfg_wdata[IGN_CNT_W-1:0];
        REG_IGN_A:     ign_label_nxt[0] = cfg_wdata;
        REG_IGN_B:     ign_label_nxt[1] = cfg_wdata;
        REG_IGN_C:     ign_label_nxt[2] = cfg_wdata;
        REG_IGN_D:     ign_label_nxt[3] = cfg_wdata;
        default:       ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Advance the position state
          if (in_last_class) begin
            class_index_nxt = '0;
            capt_prob_nxt   = '0;
            seen_nxt        = 1'b0;
          end else begin
            capt_prob_nxt = capt_now;
            seen_nxt      = seen_now;
            if (class_index_r < CLS_W'(MAX_CLASSES)) begin
              class_index_nxt = class_index_r + CLS_W'(1);
            end
          end

          if (mode_r) begin
            // Gradient result for every item
            out_valid_nxt   = 1'b1;
            out_value_nxt   = ignored ? '0
                              : (VALUE_W'(prob_c) - (match ? VALUE_W'(ONE_Q16) : '0));
            out_counted_nxt = !ignored;
            out_lerr_nxt    = !ignored && in_last_class && !seen_now;
            out_eop_nxt     = in_last_class;
          end else if (in_last_class) begin
            if (!ignored && seen_now) begin
              // Start the logarithm
              x_nxt     = {prob_floor, 15'b0};
              exp_nxt   = EXP_W'(16);
              frac_nxt  = '0;
              step_nxt  = '0;
              state_nxt = ST_NORM;
            end else begin
              out_valid_nxt   = 1'b1;
              out_value_nxt   = '0;
              out_counted_nxt = !ignored;
              out_lerr_nxt    = !ignored && !seen_now;
              out_eop_nxt     = 1'b1;
            end
          end
        end
      end

      ST_NORM: begin
        // Shift left one bit a cycle until the leading one reaches bit 31
        if (x_r[31]) begin
          state_nxt = ST_SQ;
        end else begin
          x_nxt   = {x_r[30:0], 1'b0};
          exp_nxt = exp_r - EXP_W'(1);
        end
      end

      ST_SQ: begin
        // One fraction bit of log2 per squaring
        x_nxt    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        frac_nxt = {frac_r[FRAC_BITS-2:0], sq_t[32]};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(FRAC_BITS - 1)) begin
          state_nxt = ST_NEG;
        end
      end

      ST_NEG: begin
        neg_nxt   = (NEG_W'(1) << 28) - {exp_r, frac_r};
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = ST_RND;
      end

      ST_RND: begin
        // Round, saturate and hand over once the result register is free
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_value_nxt   = (rnd_q > 20'd65535) ? VALUE_W'(65535) : VALUE_W'(rnd_q);
          out_counted_nxt = 1'b1;
          out_lerr_nxt    = 1'b0;
          out_eop_nxt     = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= 1'b0;
      ign_count_r   <= '0;
      for (int k = 0; k < NUM_IGN_REGS; k++) begin
        ign_label_r[k] <= '1;
      end
      class_index_r <= '0;
      capt_prob_r   <= '0;
      seen_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      ign_count_r   <= ign_count_nxt;
      ign_label_r   <= ign_label_nxt;
      class_index_r <= class_index_nxt;
      capt_prob_r   <= capt_prob_nxt;
      seen_r        <= seen_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    x_r             <= x_nxt;
    exp_r           <= exp_nxt;
    frac_r          <= frac_nxt;
    step_r          <= step_nxt;
    neg_r           <= neg_nxt;
    prod_r          <= prod_nxt;
    out_value_r     <= out_value_nxt;
    out_counted_r   <= out_counted_nxt;
    out_lerr_r      <= out_lerr_nxt;
    out_eop_r       <= out_eop_nxt;
  end

endmodule

### sv/ssce_checker.sv
// Port-level checks for the sparse softmax cross-entropy block, bound to the top level.
module ssce_props
  import ssce_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [VALUE_W-1:0] out_value,
  input logic                      out_counted,
  input logic                      out_label_error,
  input logic                      out_end_of_position
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_counted)
      && $stable(out_label_error) && $stable(out_end_of_position))
    else $error("stalled result changed");

  // Ignored positions give zero and no label error
  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_counted |-> out_value == '0 && !out_label_error)
    else $error("ignored position with nonzero result");

  // Label error only on the end of a counted position
  a_lerr_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_label_error |-> out_end_of_position && out_counted)
    else $error("label error away from position end");

endmodule

bind sparse_softmax_cross_entropy ssce_props u_ssce_props (.*);

### sim/ssce_checker.sv
// Checker for the sparse softmax cross-entropy block: predicts results and compares them.
module ssce_checker
  import ssce_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic        [PROB_W-1:0]     in_probability,
  input  logic signed [LABEL_W-1:0]    in_target_label,
  input  logic                         in_last_class,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [VALUE_W-1:0]    out_value,
  input  logic                         out_counted,
  input  logic                         out_label_error,
  input  logic                         out_end_of_position,
  input  logic                         cfg_we,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_wdata,
  output int                           n_pending,
  output int                           n_errors,
  output int                           n_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      counted;
    logic                      label_error;
    logic                      end_of_position;
  } xent_out_t;

  // Shadow configuration
  logic                 grad_mode;
  logic [IGN_CNT_W-1:0] ign_cnt;
  logic [LABEL_W-1:0]   ign_lbl [NUM_IGN_REGS];

  // Shadow position state
  int                   cls_idx;
  logic [PROB_W-1:0]    cap_prob;
  logic                 label_hit;

  xent_out_t            xent_due_q [$];

  // -ln(p) in Q4.12 from a Q1.16 code, log2 fraction by repeated squaring
  function automatic logic [VALUE_W-1:0] neg_log_q4_12(input logic [PROB_W-1:0] code);
    logic [PROB_W-1:0] pc;
    int                e;
    int                i;
    logic [63:0]       x;
    logic [63:0]       frac;
    logic [63:0]       neg;
    logic [63:0]       r;
    pc = code;
    if (pc == '0) pc = 1;
    if (pc > ONE_Q16) pc = ONE_Q16;
    e = 0;
    while (e < 16 && (pc >> (e + 1)) != 0) e++;
    x = 64'(pc) << (31 - e);
    frac = '0;
    for (i = 0; i < FRAC_BITS; i++) begin
      x = (x * x) >> 31;
      frac = frac << 1;
      if (x >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        x = x >> 1;
      end
    end
    neg = (64'd16 << FRAC_BITS) - ((64'(e) << FRAC_BITS) + frac);
    r = (neg * 64'(LN2_Q32) + (64'd1 << 43)) >> 44;
    if (r > 64'd65535) r = 64'd65535;
    return r[VALUE_W-1:0];
  endfunction

  // Work out the result of one accepted class item and advance the position state
  task automatic score_class_item(input logic [PROB_W-1:0] prob_in,
                                  input logic [LABEL_W-1:0] lbl, input logic last);
    logic [PROB_W-1:0] p;
    logic              ignored;
    logic              match;
    int                n_use;
    int                k;
    int                v;
    xent_out_t         due;
    p = (prob_in > ONE_Q16) ? ONE_Q16 : prob_in;
    n_use = (int'(ign_cnt) > MAX_IGNORES) ? MAX_IGNORES : int'(ign_cnt);
    ignored = 1'b0;
    for (k = 0; k < n_use; k++)
      if (ign_lbl[k] == lbl) ignored = 1'b1;
    match = !lbl[LABEL_W-1] && cls_idx < MAX_CLASSES && int'(lbl) == cls_idx;
    if (match) begin
      cap_prob = p;
      label_hit = 1'b1;
    end

    if (grad_mode) begin
      v = ignored ? 0 : int'(p) - (match ? int'(ONE_Q16) : 0);
      due.value = v[VALUE_W-1:0];
      due.counted = !ignored;
      due.label_error = !ignored && last && !label_hit;
      due.end_of_position = last;
      xent_due_q.push_back(due);
    end else if (last) begin
      due.value = (!ignored && label_hit) ? neg_log_q4_12(cap_prob) : '0;
      due.counted = !ignored;
      due.label_error = !ignored && !label_hit;
      due.end_of_position = 1'b1;
      xent_due_q.push_back(due);
    end

    // Close the position on its last item, otherwise step the class index
    if (last) begin
      cls_idx = 0;
      cap_prob = '0;
      label_hit = 1'b0;
    end else if (cls_idx < MAX_CLASSES) begin
      cls_idx++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      grad_mode = 1'b0;
      ign_cnt = '0;
      foreach (ign_lbl[k]) ign_lbl[k] = '1;
      cls_idx = 0;
      cap_prob = '0;
      label_hit = 1'b0;
      xent_due_q.delete();
      n_errors = 0;
      n_checked = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:      grad_mode = cfg_wdata[0];
          REG_IGN_COUNT: ign_cnt = cfg_wdata[IGN_CNT_W-1:0];
          REG_IGN_A:     ign_lbl[0] = cfg_wdata[LABEL_W-1:0];
          REG_IGN_B:     ign_lbl[1] = cfg_wdata[LABEL_W-1:0];
          REG_IGN_C:     ign_lbl[2] = cfg_wdata[LABEL_W-1:0];
          REG_IGN_D:     ign_lbl[3] = cfg_wdata[LABEL_W-1:0];
          default: ;
        endcase
      end

      // Compare an accepted result against the oldest prediction
      if (out_valid && !out_stall) begin
        if (xent_due_q.size() == 0) begin
          $error("unexpected result: value %0d counted %0b label_error %0b eop %0b",
                 out_value, out_counted, out_label_error, out_end_of_position);
          n_errors++;
        end else begin
          xent_out_t due;
          due = xent_due_q.pop_front();
          n_checked++;
          if (out_value !== due.value) begin
            $error("value: expected %0d, got %0d", due.value, out_value);
            n_errors++;
          end
          if (out_counted !== due.counted) begin
            $error("counted: expected %0b, got %0b", due.counted, out_counted);
            n_errors++;
          end
          if (out_label_error !== due.label_error) begin
            $error("label_error: expected %0b, got %0b", due.label_error, out_label_error);
            n_errors++;
          end
          if (out_end_of_position !== due.end_of_position) begin
            $error("end_of_position: expected %0b, got %0b",
                   due.end_of_position, out_end_of_position);
            n_errors++;
          end
        end
      end

      // Predict from an accepted class item
      if (in_valid && !in_stall)
        score_class_item(in_probability, in_target_label, in_last_class);
    end
    n_pending = xent_due_q.size();
  end

endmodule

### sim/sparse_softmax_cross_entropy_tb.sv
// Testbench top for the sparse softmax cross-entropy block: stimulus, idling and verdict.
module sparse_softmax_cross_entropy_tb;
  import ssce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOG_DRAIN = 100;
  localparam int SEG_ITEMS = 125;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [PROB_W-1:0]      in_probability = '0;
  logic [LABEL_W-1:0]     in_target_label = '0;
  logic                   in_last_class = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [VALUE_W-1:0]     out_value;
  logic                   out_counted;
  logic                   out_label_error;
  logic                   out_end_of_position;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int n_pending;
  int n_errors;
  int n_checked;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int items_sent = 0;
  int positions_sent = 0;
  int ign_used = 0;
  logic [LABEL_W-1:0] ign_lbl [NUM_IGN_REGS];

  sparse_softmax_cross_entropy u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_probability      (in_probability),
    .in_target_label     (in_target_label),
    .in_last_class       (in_last_class),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_value           (out_value),
    .out_counted         (out_counted),
    .out_label_error     (out_label_error),
    .out_end_of_position (out_end_of_position),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  ssce_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_probability      (in_probability),
    .in_target_label     (in_target_label),
    .in_last_class       (in_last_class),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_value           (out_value),
    .out_counted         (out_counted),
    .out_label_error     (out_label_error),
    .out_end_of_position (out_end_of_position),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .n_pending           (n_pending),
    .n_errors            (n_errors),
    .n_checked           (n_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Drive a register write and wait for a clock edge; the caller drops cfg_we after the batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Offer one class item, idling first at random, and wait until it is taken
  task automatic send_item(input logic [PROB_W-1:0] prob, input logic [LABEL_W-1:0] lbl,
                           input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_probability <= prob;
    in_target_label <= lbl;
    in_last_class <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (last) positions_sent++;
  endtask

  // Drain all results, then give the log unit time to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (LOG_DRAIN) @(posedge clk);
  endtask

  function automatic logic [PROB_W-1:0] rand_prob();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(5))
        0: return 17'd0;
        1: return 17'd1;
        2: return 17'd2;
        3: return 17'd65535;
        4: return ONE_Q16;
        default: return 17'h1FFFF;
      endcase
    end
    if (pick < 20) return PROB_W'($urandom_range(0, 131071));
    if (pick < 30) return PROB_W'($urandom_range(0, 255));
    return PROB_W'($urandom_range(0, 65536));
  endfunction

  // One position: mostly a proper label, sometimes ignored, out of range or noisy
  task automatic run_position(input int n_cls);
    logic [LABEL_W-1:0] lbl;
    logic               noisy;
    int                 pick;
    int                 i;
    pick = $urandom_range(99);
    if (pick < 65) lbl = LABEL_W'($urandom_range(0, n_cls - 1));
    else if (pick < 77 && ign_used > 0) lbl = ign_lbl[$urandom_range(0, ign_used - 1)];
    else if (pick < 87) lbl = LABEL_W'(n_cls + $urandom_range(0, 3));
    else lbl = LABEL_W'($urandom);
    noisy = ($urandom_range(99) < 5);
    for (i = 0; i < n_cls; i++)
      send_item(rand_prob(), noisy ? LABEL_W'($urandom) : lbl, i == n_cls - 1);
  endtask

  initial begin
    int seg;
    int cnt;
    int k;
    int seg_start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Loss mode at reset settings: full and zero probability, above one, label errors
    send_item(ONE_Q16, 16'sd0, 1'b1);
    send_item(17'd0, 16'sd1, 1'b0);
    send_item(17'd0, 16'sd1, 1'b1);
    send_item(17'd1, 16'sd2, 1'b0);
    send_item(17'h1FFFF, 16'sd2, 1'b0);
    send_item(17'd65535, 16'sd2, 1'b1);
    send_item(17'd4000, 16'sd5, 1'b0);
    send_item(17'd9000, 16'sd5, 1'b1);
    send_item(17'd30000, -16'sd1, 1'b1);
    settle();

    // Ignore the reset label value -1
    write_reg(REG_IGN_COUNT, 16'd1);
    cfg_we <= 1'b0;
    send_item(17'd100, -16'sd1, 1'b0);
    send_item(17'd200, -16'sd1, 1'b1);
    settle();

    // Gradient mode, ignore count above the register count, extreme labels
    write_reg(REG_MODE, 16'd1);
    write_reg(REG_IGN_COUNT, 16'd7);
    write_reg(REG_IGN_A, 16'h8000);
    write_reg(REG_IGN_B, 16'h7FFF);
    write_reg(REG_IGN_C, 16'd0);
    write_reg(REG_IGN_D, 16'd3);
    cfg_we <= 1'b0;
    send_item(17'd500, 16'sh7FFF, 1'b0);
    send_item(17'd600, 16'sh7FFF, 1'b1);
    send_item(ONE_Q16, 16'sd1, 1'b0);
    send_item(17'd0, 16'sd1, 1'b0);
    send_item(17'h1FFFF, 16'sd1, 1'b1);
    send_item(17'd1234, 16'sd0, 1'b1);
    send_item(17'd77, 16'sd4, 1'b0);
    send_item(17'd88, 16'sd4, 1'b1);

    // Switch to loss mode in the middle of a position
    send_item(17'd1000, 16'sd2, 1'b0);
    settle();
    write_reg(REG_MODE, 16'd0);
    cfg_we <= 1'b0;
    send_item(17'd2000, 16'sd2, 1'b0);
    send_item(17'd3000, 16'sd2, 1'b1);
    settle();

    // Random segments: four idle profiles, each in loss then gradient mode
    for (seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
      endcase
      if (seg == 0) begin
        cnt = 0;
        for (k = 0; k < NUM_IGN_REGS; k++)
          ign_lbl[k] = '1;
      end else if (seg == 1) begin
        cnt = 4;
        ign_lbl[0] = 16'h8000;
        ign_lbl[1] = 16'h7FFF;
        ign_lbl[2] = 16'd0;
        ign_lbl[3] = 16'd5;
      end else begin
        cnt = $urandom_range(0, 7);
        for (k = 0; k < NUM_IGN_REGS; k++)
          ign_lbl[k] = $urandom_range(1) ? LABEL_W'($urandom_range(0, 9)) : LABEL_W'($urandom);
      end
      ign_used = (cnt > MAX_IGNORES) ? MAX_IGNORES : cnt;
      write_reg(REG_MODE, CFG_DATA_W'(seg % 2));
      write_reg(REG_IGN_COUNT, CFG_DATA_W'(cnt));
      write_reg(REG_IGN_A, ign_lbl[0]);
      write_reg(REG_IGN_B, ign_lbl[1]);
      write_reg(REG_IGN_C, ign_lbl[2]);
      write_reg(REG_IGN_D, ign_lbl[3]);
      cfg_we <= 1'b0;

      seg_start = items_sent;
      while (items_sent - seg_start < SEG_ITEMS)
        run_position(($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40));
      settle();
    end

    $display("Summary: %0d class items in %0d positions, %0d results checked.",
             items_sent, positions_sent, n_checked);
    $display("Covered loss and gradient modes, ignore counts 0 to 7, four idle profiles.");
    if (n_errors == 0 && n_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/ssce_pkg.sv
sv/sparse_softmax_cross_entropy.sv
sv/ssce_checker.sv
sim/ssce_checker.sv
sim/sparse_softmax_cross_entropy_tb.sv
